/* rtl/wpw_pkg.sv */
// Shared types and constants for the pixel line waveform driver.
package wpw_pkg;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_LATCH = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_HIGH  = 2'd1,
		PH_LOW   = 2'd2,
		PH_LATCH = 2'd3
	} phase_t;

	localparam int unsigned PIXEL_W  = 24;
	localparam int unsigned BITS_W   = 5;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned PADDR_W  = 5;
	localparam logic [BITS_W-1:0] PIXEL_BITS = 5'd24;

	// register index taken from paddr[4:2]
	localparam logic [2:0] REG_ONE_HIGH  = 3'd0;
	localparam logic [2:0] REG_ONE_LOW   = 3'd1;
	localparam logic [2:0] REG_ZERO_HIGH = 3'd2;
	localparam logic [2:0] REG_ZERO_LOW  = 3'd3;
	localparam logic [2:0] REG_LATCH     = 3'd4;

	localparam logic [7:0]  RST_ONE_HIGH  = 8'd17;
	localparam logic [7:0]  RST_ONE_LOW   = 8'd8;
	localparam logic [7:0]  RST_ZERO_HIGH = 8'd4;
	localparam logic [7:0]  RST_ZERO_LOW  = 8'd14;
	localparam logic [15:0] RST_LATCH     = 16'd7200;

	typedef struct packed {
		op_t                op;
		logic [PIXEL_W-1:0] pixel;
	} cmd_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic accepted;
	} res_t;

	typedef struct packed {
		logic [7:0]  one_high;
		logic [7:0]  one_low;
		logic [7:0]  zero_high;
		logic [7:0]  zero_low;
		logic [15:0] latch;
	} cfg_t;

	// a zero register value counts as one tick
	function automatic logic [COUNT_W-1:0] at_least_one(input logic [COUNT_W-1:0] v);
		return (v == '0) ? COUNT_W'(1) : v;
	endfunction

endpackage

/* rtl/wpw_front.sv */
// Front end: decodes incoming requests and queues them for the engine.
module wpw_front #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [1:0]                   action,
	input  logic [7:0]                   red,
	input  logic [7:0]                   green,
	input  logic [7:0]                   blue,
	output logic                         cmd_valid,
	output wpw_pkg::cmd_t                cmd,
	input  logic                         cmd_take
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	wpw_pkg::cmd_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	wpw_pkg::cmd_t  cmd_in;
	logic           do_push, do_pop;

	always_comb begin
		cmd_in.pixel = {green, red, blue};
		unique case (action)
			wpw_pkg::ACT_LOAD:  cmd_in.op = wpw_pkg::ACT_LOAD;
			wpw_pkg::ACT_LATCH: cmd_in.op = wpw_pkg::ACT_LATCH;
			wpw_pkg::ACT_TICK:  cmd_in.op = wpw_pkg::ACT_TICK;
			default: cmd_in.op = wpw_pkg::ACT_NONE;
		endcase
	end

	assign full      = (count_q == CNT_W'(DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/wpw_engine.sv */
// Back end: waveform state machine and result queue.
module wpw_engine #(
	parameter int unsigned DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  wpw_pkg::cfg_t cfg,
	input  logic          cmd_valid,
	input  wpw_pkg::cmd_t cmd,
	output logic          cmd_take,
	output logic          empty,
	input  logic          pop,
	output logic          line_level,
	output logic          busy_res,
	output logic          accepted
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned PW    = wpw_pkg::PIXEL_W;
	localparam int unsigned CW    = wpw_pkg::COUNT_W;

	wpw_pkg::phase_t            phase_q, phase_d, phase_a;
	logic [PW-1:0]              shift_q, shift_d, shift_a, shift_nx;
	logic [wpw_pkg::BITS_W-1:0] bits_q, bits_d, bits_a;
	logic [CW-1:0]              count_q, count_d, count_a;
	wpw_pkg::res_t              res;

	wpw_pkg::res_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] rcount_q;
	logic             res_full, do_pop;

	assign res_full = (rcount_q == CNT_W'(DEPTH));
	assign cmd_take = cmd_valid && !res_full;
	assign do_pop   = pop && !empty;
	assign shift_nx = {shift_q[PW-2:0], 1'b0};

	// request stage: load or latch start, then tick advance from the current state
	always_comb begin
		phase_a = phase_q;
		shift_a = shift_q;
		bits_a  = bits_q;
		count_a = count_q;
		res.accepted = 1'b0;
		if (cmd.op == wpw_pkg::ACT_LOAD && phase_q == wpw_pkg::PH_IDLE) begin
			shift_a = cmd.pixel;
			bits_a  = wpw_pkg::PIXEL_BITS;
			phase_a = wpw_pkg::PH_HIGH;
			count_a = wpw_pkg::at_least_one(CW'(cmd.pixel[PW-1] ? cfg.one_high
				: cfg.zero_high));
			res.accepted = 1'b1;
		end else if (cmd.op == wpw_pkg::ACT_LATCH && phase_q == wpw_pkg::PH_IDLE) begin
			phase_a = wpw_pkg::PH_LATCH;
			count_a = wpw_pkg::at_least_one(cfg.latch);
			res.accepted = 1'b1;
		end
		res.line_level = (phase_a == wpw_pkg::PH_HIGH);
		res.busy_res   = (phase_a != wpw_pkg::PH_IDLE);

		phase_d = phase_a;
		shift_d = shift_a;
		bits_d  = bits_a;
		count_d = count_a;
		if (cmd.op == wpw_pkg::ACT_TICK && phase_q != wpw_pkg::PH_IDLE) begin
			priority if (count_q > CW'(1)) begin
				count_d = count_q - 1'b1;
			end else if (phase_q == wpw_pkg::PH_HIGH) begin
				phase_d = wpw_pkg::PH_LOW;
				count_d = wpw_pkg::at_least_one(CW'(shift_q[PW-1] ? cfg.one_low
					: cfg.zero_low));
			end else if (phase_q == wpw_pkg::PH_LOW && bits_q > 5'd1) begin
				bits_d  = bits_q - 1'b1;
				shift_d = shift_nx;
				phase_d = wpw_pkg::PH_HIGH;
				count_d = wpw_pkg::at_least_one(CW'(shift_nx[PW-1] ? cfg.one_high
					: cfg.zero_high));
			end else begin
				phase_d = wpw_pkg::PH_IDLE;
				count_d = '0;
				bits_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wpw_pkg::PH_IDLE;
			shift_q <= '0;
			bits_q  <= '0;
			count_q <= '0;
		end else if (cmd_take) begin
			phase_q <= phase_d;
			shift_q <= shift_d;
			bits_q  <= bits_d;
			count_q <= count_d;
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			mem_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			rcount_q <= '0;
		end else begin
			if (cmd_take) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (cmd_take && !do_pop) begin
				rcount_q <= rcount_q + 1'b1;
			end else if (do_pop && !cmd_take) begin
				rcount_q <= rcount_q - 1'b1;
			end
		end
	end

	assign empty      = (rcount_q == '0);
	assign line_level = mem_q[rd_ptr_q].line_level;
	assign busy_res   = mem_q[rd_ptr_q].busy_res;
	assign accepted   = mem_q[rd_ptr_q].accepted;

endmodule

/* rtl/ws2812_pixel_waveform_top.sv */
// Top level of the single-wire pixel line waveform driver.
// Single-wire LED pixel line driver. Each request is a load (24-bit pixel sent
// green, red, blue, MSB first), a latch reset, or a tick that advances time by
// one unit. Every request returns one result: line level during that request,
// busy, and whether a load/reset was taken (only taken while idle). Bit pulse
// widths and the latch length come from five tick registers on the APB port
// (0x00 one high, 0x04 one low, 0x08 zero high, 0x0C zero low, 0x10 latch);
// a value of zero counts as one tick. Throughput is one request per clock
// while the result queue has room, set by the engine, which retires one
// request per cycle in a registered state update. A request accepted into
// the request queue is taken by the engine once the result queue has room,
// and its result is on the result ports right after that edge, ready to pop.
// Request and result queues decouple both sides so either can stall.
// Write tick registers only while no requests are outstanding.
module ws2812_pixel_waveform_top #(
	parameter int unsigned CMD_DEPTH = 4,
	parameter int unsigned RES_DEPTH = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request side
	input  logic                        push,
	output logic                        full,
	input  logic [1:0]                  action,
	input  logic [7:0]                  red,
	input  logic [7:0]                  green,
	input  logic [7:0]                  blue,
	// result side
	output logic                        empty,
	input  logic                        pop,
	output logic                        line_level,
	output logic                        busy_res,
	output logic                        accepted,
	// register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wpw_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	wpw_pkg::cfg_t cfg_q;
	wpw_pkg::cmd_t cmd;
	logic          cmd_valid, cmd_take;
	logic          wr_en;
	logic [2:0]    reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// tick registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.one_high  <= wpw_pkg::RST_ONE_HIGH;
			cfg_q.one_low   <= wpw_pkg::RST_ONE_LOW;
			cfg_q.zero_high <= wpw_pkg::RST_ZERO_HIGH;
			cfg_q.zero_low  <= wpw_pkg::RST_ZERO_LOW;
			cfg_q.latch     <= wpw_pkg::RST_LATCH;
		end else if (wr_en) begin
			unique case (reg_idx)
				wpw_pkg::REG_ONE_HIGH:  cfg_q.one_high  <= pwdata[7:0];
				wpw_pkg::REG_ONE_LOW:   cfg_q.one_low   <= pwdata[7:0];
				wpw_pkg::REG_ZERO_HIGH: cfg_q.zero_high <= pwdata[7:0];
				wpw_pkg::REG_ZERO_LOW:  cfg_q.zero_low  <= pwdata[7:0];
				wpw_pkg::REG_LATCH:     cfg_q.latch     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// readback
	always_comb begin
		unique case (reg_idx)
			wpw_pkg::REG_ONE_HIGH:  prdata = {24'd0, cfg_q.one_high};
			wpw_pkg::REG_ONE_LOW:   prdata = {24'd0, cfg_q.one_low};
			wpw_pkg::REG_ZERO_HIGH: prdata = {24'd0, cfg_q.zero_high};
			wpw_pkg::REG_ZERO_LOW:  prdata = {24'd0, cfg_q.zero_low};
			wpw_pkg::REG_LATCH:     prdata = {16'd0, cfg_q.latch};
			default:                prdata = '0;
		endcase
	end

	wpw_front #(
		.DEPTH(CMD_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.action    (action),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	wpw_engine #(
		.DEPTH(RES_DEPTH)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_take   (cmd_take),
		.empty      (empty),
		.pop        (pop),
		.line_level (line_level),
		.busy_res   (busy_res),
		.accepted   (accepted)
	);

endmodule

/* test/ws2812_pixel_waveform_top_test.sv */
// Testbench for the pixel line waveform driver: directed table, random pixel/latch traffic.
`timescale 1ns / 1ps

module ws2812_pixel_waveform_top_test;
	import wpw_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int HOLD_CYCLES = 60;    // receiver hold-off, long enough to fill both queues
	localparam int SETTLE      = 4;     // padding after the last result is popped
	localparam int PHASE_REQS  = 60;    // random requests per config setting

	// One directed request. Rows with 'typed' set carry their own expected status;
	// the rest are checked against the line predictor. 'drain' ticks until idle.
	typedef struct packed {
		op_t        op;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       typed;
		res_t       want;      // {line_level, busy_res, accepted}
		logic       drain;
	} step_row_t;

	// Short tick settings throughout: one high 2, one low 1, zero high 1,
	// zero low 2, latch 3.
	localparam step_row_t DIRECTED_STEPS [16] = '{
		// idle: tick and the unused action report all zero
		'{ACT_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 3'b000, 1'b0},
		'{ACT_NONE,  8'hff, 8'hff, 8'hff, 1'b1, 3'b000, 1'b0},
		// latch taken, then loads/latches/unused refused while it runs
		'{ACT_LATCH, 8'h00, 8'h00, 8'h00, 1'b1, 3'b011, 1'b0},
		'{ACT_LOAD,  8'hff, 8'hff, 8'hff, 1'b1, 3'b010, 1'b0},
		'{ACT_LATCH, 8'h00, 8'h00, 8'h00, 1'b1, 3'b010, 1'b0},
		'{ACT_NONE,  8'h00, 8'h00, 8'h00, 1'b1, 3'b010, 1'b0},
		'{ACT_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 3'b010, 1'b1},
		// load taken into the high pulse, requests refused during it
		'{ACT_LOAD,  8'h00, 8'hff, 8'h00, 1'b1, 3'b111, 1'b0},
		'{ACT_LOAD,  8'hff, 8'h00, 8'hff, 1'b1, 3'b110, 1'b0},
		'{ACT_LATCH, 8'h00, 8'h00, 8'h00, 1'b1, 3'b110, 1'b0},
		'{ACT_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 3'b110, 1'b0},
		'{ACT_NONE,  8'h00, 8'h00, 8'h00, 1'b1, 3'b110, 1'b1},
		// all-zero and all-one pixels, then a mixed one for the bit order
		'{ACT_LOAD,  8'h00, 8'h00, 8'h00, 1'b1, 3'b111, 1'b1},
		'{ACT_LOAD,  8'hff, 8'hff, 8'hff, 1'b1, 3'b111, 1'b1},
		'{ACT_LOAD,  8'h01, 8'h80, 8'ha5, 1'b0, 3'b000, 1'b1},
		'{ACT_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 3'b000, 1'b0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic [1:0]           action;
	logic [7:0]           red;
	logic [7:0]           green;
	logic [7:0]           blue;
	logic                 empty;
	logic                 pop;
	logic                 line_level;
	logic                 busy_res;
	logic                 accepted;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	// Line predictor state and its copy of the tick registers
	cfg_t                 tick_cfg = '{RST_ONE_HIGH, RST_ONE_LOW, RST_ZERO_HIGH,
	                                   RST_ZERO_LOW, RST_LATCH};
	logic [PIXEL_W-1:0]   px_shift = '0;
	logic [BITS_W-1:0]    px_bits  = '0;
	phase_t               ln_phase = PH_IDLE;
	logic [COUNT_W-1:0]   ln_count = '0;

	res_t                 status_due[$];   // predicted status per accepted request, oldest first
	res_t                 got_res;
	res_t                 want_res;
	int                   errors    = 0;
	int                   reqs_sent = 0;
	int                   tx_idle   = 18;  // percent of cycles the sender holds back
	int                   rx_idle   = 64;  // percent of cycles the receiver holds back
	bit                   hold_req  = 1'b0;

	ws2812_pixel_waveform_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.action     (action),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.empty      (empty),
		.pop        (pop),
		.line_level (line_level),
		.busy_res   (busy_res),
		.accepted   (accepted),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// zero in a tick register still lasts one tick
	function automatic logic [COUNT_W-1:0] min_one_tick(input logic [COUNT_W-1:0] v);
		return (v == '0) ? COUNT_W'(1) : v;
	endfunction

	function automatic void enter_high_pulse();
		ln_phase = PH_HIGH;
		ln_count = min_one_tick(COUNT_W'(px_shift[PIXEL_W-1] ? tick_cfg.one_high
		                                                      : tick_cfg.zero_high));
	endfunction

	// Status reported for one request, then the line state moves on (ticks only).
	function automatic res_t line_status_next(input op_t op, input logic [PIXEL_W-1:0] pix);
		res_t r;
		logic was_idle;
		was_idle = (ln_phase == PH_IDLE);
		r = '0;
		if (op == ACT_LOAD && was_idle) begin
			px_shift = pix;
			px_bits  = PIXEL_BITS;
			enter_high_pulse();
			r.accepted = 1'b1;
		end else if (op == ACT_LATCH && was_idle) begin
			ln_phase = PH_LATCH;
			ln_count = min_one_tick(tick_cfg.latch);
			r.accepted = 1'b1;
		end
		r.line_level = (ln_phase == PH_HIGH);
		r.busy_res   = (ln_phase != PH_IDLE);
		if (op == ACT_TICK && ln_phase != PH_IDLE) begin
			if (ln_count > 1) begin
				ln_count = ln_count - 1'b1;
			end else if (ln_phase == PH_HIGH) begin
				ln_phase = PH_LOW;
				ln_count = min_one_tick(COUNT_W'(px_shift[PIXEL_W-1] ? tick_cfg.one_low
				                                                      : tick_cfg.zero_low));
			end else if (ln_phase == PH_LOW && px_bits > 1) begin
				px_bits  = px_bits - 1'b1;
				px_shift = px_shift << 1;
				enter_high_pulse();
			end else begin
				// last low pulse or latch done
				ln_phase = PH_IDLE;
				ln_count = '0;
				px_bits  = '0;
			end
		end
		return r;
	endfunction

	// Offer one request; on acceptance record its predicted (or typed) status.
	task automatic offer_req(input op_t op, input logic [7:0] r, input logic [7:0] g,
	                         input logic [7:0] b, input logic typed, input res_t want);
		res_t exp_res;
		while ($urandom_range(99) < tx_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push   <= 1'b1;
		action <= op;
		red    <= r;
		green  <= g;
		blue   <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		exp_res = line_status_next(op, {g, r, b});
		if (typed)
			exp_res = want;
		status_due.push_back(exp_res);
		reqs_sent++;
	endtask

	task automatic offer_rand(input op_t op);
		offer_req(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
		          8'($urandom_range(255)), 1'b0, '0);
	endtask

	task automatic drain_line();
		while (ln_phase != PH_IDLE)
			offer_rand(ACT_TICK);
	endtask

	// Tick the line idle, stop offering, wait for every result plus the pipeline.
	task automatic quiesce();
		drain_line();
		push <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB write: setup, access, then idle with psel low so back-to-back writes never
	// lower and raise psel in the same step.
	task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'h0000, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_ONE_HIGH:  tick_cfg.one_high  = val[7:0];
			REG_ONE_LOW:   tick_cfg.one_low   = val[7:0];
			REG_ZERO_HIGH: tick_cfg.zero_high = val[7:0];
			REG_ZERO_LOW:  tick_cfg.zero_low  = val[7:0];
			REG_LATCH:     tick_cfg.latch     = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// APB read: setup, access, compare the data seen at the access edge.
	task automatic cfg_read_check(input logic [2:0] idx, input logic [31:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			$display("%0t: register %0d expected %h got %h", $time, idx, want, prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic cfg_all(input logic [7:0] one_hi, input logic [7:0] one_lo,
	                       input logic [7:0] zero_hi, input logic [7:0] zero_lo,
	                       input logic [15:0] latch_len);
		quiesce();
		cfg_write(REG_ONE_HIGH, {8'h00, one_hi});
		cfg_write(REG_ONE_LOW, {8'h00, one_lo});
		cfg_write(REG_ZERO_HIGH, {8'h00, zero_hi});
		cfg_write(REG_ZERO_LOW, {8'h00, zero_lo});
		cfg_write(REG_LATCH, latch_len);
	endtask

	// mostly short pulses so many pixels fit in the run; zero now and then
	function automatic logic [7:0] rand_ticks();
		case ($urandom_range(9))
			0:       return 8'h00;
			1:       return 8'($urandom_range(12, 5));
			default: return 8'($urandom_range(4, 1));
		endcase
	endfunction

	// Mostly whole pixels/latches ticked to the end with refused requests mixed in;
	// the rest is loose noise over all four actions.
	task automatic run_random(input int n);
		int start;
		start = reqs_sent;
		while (reqs_sent - start < n) begin
			if ($urandom_range(3) != 0) begin
				if ($urandom_range(3) != 0)
					offer_rand(ACT_LOAD);
				else
					offer_rand(ACT_LATCH);
				while (ln_phase != PH_IDLE) begin
					if ($urandom_range(9) == 0)
						offer_rand(op_t'($urandom_range(3)));
					else
						offer_rand(ACT_TICK);
				end
			end else begin
				repeat ($urandom_range(4, 1)) offer_rand(op_t'($urandom_range(3)));
			end
		end
	endtask

	// One idling mode at two random tick settings; the receiver holds off at the
	// start of the first batch.
	task automatic run_phase();
		cfg_all(rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks(),
		        16'($urandom_range(40)));
		hold_req = 1'b1;
		run_random(PHASE_REQS);
		cfg_all(rand_ticks(), rand_ticks(), rand_ticks(), rand_ticks(),
		        16'($urandom_range(40)));
		run_random(PHASE_REQS);
	endtask

	// Receiver: random pops, plus a long hold-off on request so the queues back up.
	initial begin
		forever begin
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			pop <= ($urandom_range(99) >= rx_idle);
			@(posedge clk);
		end
	end

	// Result checker: every popped status against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			got_res = '{line_level, busy_res, accepted};
			if (status_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %b", $time, got_res);
				errors++;
			end else begin
				want_res = status_due.pop_front();
				if (got_res.line_level !== want_res.line_level) begin
					$display("%0t: line_level expected %b got %b", $time,
					         want_res.line_level, got_res.line_level);
					errors++;
				end
				if (got_res.busy_res !== want_res.busy_res) begin
					$display("%0t: busy_res expected %b got %b", $time,
					         want_res.busy_res, got_res.busy_res);
					errors++;
				end
				if (got_res.accepted !== want_res.accepted) begin
					$display("%0t: accepted expected %b got %b", $time,
					         want_res.accepted, got_res.accepted);
					errors++;
				end
			end
		end
	end

	// Stimulus
	initial begin
		arst_n  = 1'b0;
		push    <= 1'b0;
		action  <= ACT_NONE;
		red     <= '0;
		green   <= '0;
		blue    <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick registers read back their reset values
		cfg_read_check(REG_ONE_HIGH, 32'(RST_ONE_HIGH));
		cfg_read_check(REG_ONE_LOW, 32'(RST_ONE_LOW));
		cfg_read_check(REG_ZERO_HIGH, 32'(RST_ZERO_HIGH));
		cfg_read_check(REG_ZERO_LOW, 32'(RST_ZERO_LOW));
		cfg_read_check(REG_LATCH, 32'(RST_LATCH));

		// directed table at short tick settings (sender 18%, receiver 64% idle)
		cfg_all(8'd2, 8'd1, 8'd1, 8'd2, 16'd3);
		for (int i = 0; i < $size(DIRECTED_STEPS); i++) begin
			offer_req(DIRECTED_STEPS[i].op, DIRECTED_STEPS[i].red, DIRECTED_STEPS[i].green,
			          DIRECTED_STEPS[i].blue, DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].want);
			if (DIRECTED_STEPS[i].drain)
				drain_line();
		end

		run_phase();

		tx_idle = 64;
		rx_idle = 18;
		run_phase();

		// no idling from here: register extremes first
		tx_idle = 0;
		rx_idle = 0;
		// all registers zero: every pulse and the latch last one tick
		cfg_all(8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
		offer_rand(ACT_LOAD);
		drain_line();
		offer_rand(ACT_LATCH);
		drain_line();
		cfg_all(8'h01, 8'h01, 8'h01, 8'h01, 16'h0001);
		offer_rand(ACT_LOAD);
		drain_line();
		offer_rand(ACT_LATCH);
		drain_line();
		// longest one-bit high pulse on the last bit only, latch past one byte
		cfg_all(8'hff, 8'h01, 8'h01, 8'h01, 16'h0100);
		offer_req(ACT_LOAD, 8'h00, 8'h00, 8'h01, 1'b0, '0);
		drain_line();
		offer_rand(ACT_LATCH);
		drain_line();

		run_phase();

		push <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE * 4) @(posedge clk);
		if (errors == 0)
			$display("ws2812_pixel_waveform_top test passed");
		else
			$display("ws2812_pixel_waveform_top test failed");
		$finish;
	end

	// Watchdog: slowest correct run stays well under 0.1 ms of simulated time.
	initial begin
		#(1_000_000);
		$display("ws2812_pixel_waveform_top test failed");
		$finish;
	end

endmodule
